/* design/qpht_pkg.sv */
// Package for the quadratic probe hash table: sizes, status codes and item types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package qpht_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int CFG_W       = 11;

  localparam int KEY_W    = 16;
  localparam int YEAR_W   = 12;
  localparam int PROF_W   = 32;
  localparam int HANDLE_W = 16;

  localparam int Q_DEPTH = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                mode;
    logic [KEY_W-1:0]    course_number;
    logic [YEAR_W-1:0]   course_year;
    logic [PROF_W-1:0]   prof_id;
    logic [HANDLE_W-1:0] record_handle;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [HANDLE_W-1:0] found_handle;
    logic [CNT_W-1:0]    probe_count;
  } out_item_t;

  typedef struct packed {
    in_item_t          item;
    logic [SLOT_W-1:0] start_slot;
  } job_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    course;
    logic [YEAR_W-1:0]   year;
    logic [PROF_W-1:0]   prof;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

endpackage
`default_nettype wire

/* design/qpht_front.sv */
// Front end: accepts items and works out the home slot, course number mod table size.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpht_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear_done,
  input  wire logic [qpht_pkg::CNT_W-1:0] n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire qpht_pkg::in_item_t      in_item,
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output qpht_pkg::job_t               job
);

  // Restoring remainder, a few key bits per cycle.
  localparam int R      = 4;
  localparam int STEPS  = qpht_pkg::KEY_W / R;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t                        state;
  qpht_pkg::in_item_t             item;
  logic [qpht_pkg::KEY_W-1:0]     key_shift;
  logic [qpht_pkg::SLOT_W-1:0]    rem;
  logic [qpht_pkg::SLOT_W-1:0]    rem_next;
  logic [STEP_W-1:0]              step_cnt;

  always_comb begin
    logic [qpht_pkg::SLOT_W-1:0] rem_v;
    logic [qpht_pkg::CNT_W-1:0]  trial;
    rem_v = rem;
    for (int k = 0; k < R; k++) begin
      trial = {rem_v, key_shift[qpht_pkg::KEY_W-1-k]};
      if (trial >= n) begin
        trial = trial - n;
      end
      rem_v = trial[qpht_pkg::SLOT_W-1:0];
    end
    rem_next = rem_v;
  end

  assign in_ready  = (state == F_IDLE) && clear_done;
  assign job_valid = (state == F_PUSH);
  assign job       = '{item: item, start_slot: rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            item      <= in_item;
            key_shift <= in_item.course_number;
            rem       <= '0;
            step_cnt  <= '0;
            state     <= F_DIV;
          end
        end
        F_DIV: begin
          rem       <= rem_next;
          key_shift <= key_shift << R;
          step_cnt  <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/qpht_queue.sv */
// Short job queue between the front end and the probe engine.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpht_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire qpht_pkg::job_t push_job,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output qpht_pkg::job_t      pop_job
);

  localparam int PTR_W = (qpht_pkg::Q_DEPTH > 1) ? $clog2(qpht_pkg::Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(qpht_pkg::Q_DEPTH + 1);

  qpht_pkg::job_t     buffer [qpht_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != FILL_W'(qpht_pkg::Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = buffer[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/qpht_back.sv */
// Probe engine: slot memory, clearing pass after reset, quadratic walk and result register.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qpht_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [qpht_pkg::CNT_W-1:0] n,
  input  wire logic                       job_valid,
  output logic                            job_ready,
  input  wire qpht_pkg::job_t             job,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output qpht_pkg::out_item_t             out_item,
  output logic                            clear_done
);

  localparam int SUM_W = qpht_pkg::CNT_W + 1;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_POST} bstate_t;

  bstate_t                      state;
  logic [qpht_pkg::SLOT_W-1:0]  clr_addr;
  qpht_pkg::in_item_t           cur;
  logic [qpht_pkg::SLOT_W-1:0]  idx;
  logic [qpht_pkg::CNT_W-1:0]   step;
  logic [qpht_pkg::CNT_W-1:0]   cnt;
  qpht_pkg::out_item_t          res;

  qpht_pkg::slot_entry_t        mem [qpht_pkg::TABLE_SLOTS];
  qpht_pkg::slot_entry_t        rdata;
  qpht_pkg::slot_entry_t        wdata;
  logic [qpht_pkg::SLOT_W-1:0]  waddr;
  logic [qpht_pkg::SLOT_W-1:0]  rd_addr;
  logic                         we;

  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_red;
  logic [qpht_pkg::SLOT_W-1:0]  idx_next;
  logic                         key_match;
  logic                         last_probe;
  logic                         probe_done;
  qpht_pkg::out_item_t          probe_res;

  // Next slot of the walk: idx + (2i + 1), brought back below n.
  always_comb begin
    sum = SUM_W'(idx) + SUM_W'(step);
    if (sum >= {n, 1'b0}) begin
      sum_red = sum - {n, 1'b0};
    end else if (sum >= SUM_W'(n)) begin
      sum_red = sum - SUM_W'(n);
    end else begin
      sum_red = sum;
    end
    idx_next = sum_red[qpht_pkg::SLOT_W-1:0];
  end

  assign rd_addr    = (state == B_IDLE) ? job.start_slot : idx_next;
  assign key_match  = (rdata.course == cur.course_number) && (rdata.year == cur.course_year)
                      && (rdata.prof == cur.prof_id);
  assign last_probe = (cnt == n);

  always_comb begin
    probe_done            = 1'b0;
    probe_res.status      = qpht_pkg::STATUS_NOT_FOUND;
    probe_res.slot_index  = '0;
    probe_res.found_handle = '0;
    probe_res.probe_count = cnt;
    we    = 1'b0;
    waddr = idx;
    wdata = '{valid: 1'b1, course: cur.course_number, year: cur.course_year,
              prof: cur.prof_id, handle: cur.record_handle};
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      B_PROBE: begin
        if (cur.mode == qpht_pkg::MODE_INSERT) begin
          if (!rdata.valid) begin
            we                   = 1'b1;
            probe_done           = 1'b1;
            probe_res.status     = qpht_pkg::STATUS_INSERTED;
            probe_res.slot_index = idx;
          end else if (last_probe) begin
            probe_done       = 1'b1;
            probe_res.status = qpht_pkg::STATUS_FULL;
          end
        end else begin
          if (!rdata.valid) begin
            probe_done = 1'b1;
          end else if (key_match) begin
            probe_done             = 1'b1;
            probe_res.status       = qpht_pkg::STATUS_FOUND;
            probe_res.slot_index   = idx;
            probe_res.found_handle = rdata.handle;
          end else if (last_probe) begin
            probe_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  assign job_ready  = (state == B_IDLE);
  assign clear_done = (state != B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result that is taken while the next one is posted is replaced in B_POST.
      if (out_valid && out_ready && (state != B_POST)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + qpht_pkg::SLOT_W'(1);
          if (clr_addr == qpht_pkg::SLOT_W'(qpht_pkg::TABLE_SLOTS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job.item;
            idx   <= job.start_slot;
            step  <= qpht_pkg::CNT_W'(1);
            cnt   <= qpht_pkg::CNT_W'(1);
            state <= B_PROBE;
          end
        end
        B_PROBE: begin
          if (probe_done) begin
            res   <= probe_res;
            state <= B_POST;
          end else begin
            idx  <= idx_next;
            step <= step + qpht_pkg::CNT_W'(2);
            cnt  <= cnt + qpht_pkg::CNT_W'(1);
          end
        end
        B_POST: begin
          if (!out_valid || out_ready) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/quadratic_probe_hash_table.sv */
// Top level of the quadratic probe hash table: size register, front end, queue, probe engine.
// Depends on qpht_pkg, qpht_front, qpht_queue and qpht_back.
`timescale 1ns / 1ps
`default_nettype none
// Open-addressing hash table of 1024 slots keyed by course number, year and professor id.
// Each input item is an insert or a lookup; each gives exactly one result item carrying
// a status, the slot that was written or matched, the stored handle of a found record and
// the number of slots examined. Slot i of the walk is (course_number + i*i) mod n, where n
// is the table_size register held in the range 1 to 1024. After reset a clearing pass runs
// through all 1024 slots, one a cycle, and no item is accepted until it ends; configuration
// writes are taken throughout. The front end accepts an item, works out the home slot in
// four-bit remainder steps and hands the job to the queue; the probe engine starts the
// walk, reads the slot memory once per slot examined and posts the result. Items overlap
// across the two halves: the front end can take a new item while the probe engine still
// walks for an earlier one.
module quadratic_probe_hash_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire qpht_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output qpht_pkg::out_item_t             out_item,
  input  wire logic                       cfg_we,
  input  wire logic [qpht_pkg::CFG_W-1:0] cfg_wdata
);

  // The register keeps the effective size: zero reads as one, anything beyond the
  // table reads as the full table.
  logic [qpht_pkg::CNT_W-1:0] n;

  logic           clear_done;
  logic           fr_valid;
  logic           fr_ready;
  qpht_pkg::job_t fr_job;
  logic           bk_valid;
  logic           bk_ready;
  qpht_pkg::job_t bk_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= qpht_pkg::CNT_W'(qpht_pkg::SIZE_RESET);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        n <= qpht_pkg::CNT_W'(1);
      end else if (cfg_wdata > qpht_pkg::CFG_W'(qpht_pkg::TABLE_SLOTS)) begin
        n <= qpht_pkg::CNT_W'(qpht_pkg::TABLE_SLOTS);
      end else begin
        n <= qpht_pkg::CNT_W'(cfg_wdata);
      end
    end
  end

  // Front end: takes an item once the clearing pass is over and its remainder unit is free.
  qpht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clear_done (clear_done),
    .n          (n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .job_valid  (fr_valid),
    .job_ready  (fr_ready),
    .job        (fr_job)
  );

  // Two-entry queue so that the front end can work on the next item while a probe walk runs.
  qpht_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_job   (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_job    (bk_job)
  );

  // Probe engine with the slot memory and the output register.
  qpht_back u_back (
    .clk        (clk),
    .rst        (rst),
    .n          (n),
    .job_valid  (bk_valid),
    .job_ready  (bk_ready),
    .job        (bk_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .clear_done (clear_done)
  );

endmodule
`default_nettype wire

/* design/qpht_checker.sv */
// Port-level checks of the quadratic probe hash table, bound to the top level.
// Depends on qpht_pkg and quadratic_probe_hash_table.
`timescale 1ns / 1ps
`default_nettype none
module qpht_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire qpht_pkg::in_item_t         in_item,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire qpht_pkg::out_item_t        out_item
);

  // No item is taken straight after reset: the clearing pass must run first.
  a_no_accept_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item accepted during the clearing pass");

  // An offered item stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input item withdrawn or changed while waiting");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Only a found lookup carries a handle.
  a_handle_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != qpht_pkg::STATUS_FOUND) |-> out_item.found_handle == '0)
    else $error("handle reported without a match");

  // Misses and full tables report slot zero, and every result examined at least one slot.
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == qpht_pkg::STATUS_FULL ||
                  out_item.status == qpht_pkg::STATUS_NOT_FOUND)
    |-> out_item.slot_index == '0 && out_item.probe_count != '0)
    else $error("miss result carries a slot or no probes");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);
`default_nettype wire

/* tb/sv/tb_quadratic_probe_hash_table.sv */
// Self-checking testbench for quadratic_probe_hash_table: directed and random inserts and
// lookups across many table sizes, checked against a cycle-free model of the probe walk.
// Depends on qpht_pkg and the quadratic_probe_hash_table RTL.
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;

  // Scoreboard: keeps its own copy of the slot store and the table size, works out the
  // outcome of every accepted item and checks the results against it in order.
  class hash_outcome_scoreboard;
    bit                            taken     [qpht_pkg::TABLE_SLOTS];
    logic [qpht_pkg::KEY_W-1:0]    key_of    [qpht_pkg::TABLE_SLOTS];
    logic [qpht_pkg::YEAR_W-1:0]   year_of   [qpht_pkg::TABLE_SLOTS];
    logic [qpht_pkg::PROF_W-1:0]   prof_of   [qpht_pkg::TABLE_SLOTS];
    logic [qpht_pkg::HANDLE_W-1:0] handle_of [qpht_pkg::TABLE_SLOTS];
    int unsigned                   size_n;
    qpht_pkg::out_item_t           awaited_outcomes[$];
    int                            errors;
    int                            results_seen;
    int                            n_inserted, n_found, n_missing, n_full;
    int unsigned                   longest_walk;

    function new();
      size_n = qpht_pkg::TABLE_SLOTS;
    endfunction

    // Out-of-range register values are folded into 1 .. TABLE_SLOTS.
    function void set_size(logic [qpht_pkg::CFG_W-1:0] value);
      if (value == '0) begin
        size_n = 1;
      end else if (value > qpht_pkg::CFG_W'(qpht_pkg::TABLE_SLOTS)) begin
        size_n = qpht_pkg::TABLE_SLOTS;
      end else begin
        size_n = 32'(value);
      end
    endfunction

    // Walk the probe sequence for one accepted item and queue the outcome.
    function void note_request(qpht_pkg::in_item_t it);
      qpht_pkg::out_item_t r;
      int unsigned         step;
      int unsigned         slot;
      r.status       = (it.mode == qpht_pkg::MODE_INSERT) ? qpht_pkg::STATUS_FULL
                                                          : qpht_pkg::STATUS_NOT_FOUND;
      r.slot_index   = '0;
      r.found_handle = '0;
      r.probe_count  = '0;
      for (step = 0; step < size_n; step++) begin
        slot = (32'(it.course_number) + step * step) % size_n;
        r.probe_count = qpht_pkg::CNT_W'(step + 1);
        if (it.mode == qpht_pkg::MODE_INSERT) begin
          if (!taken[slot]) begin
            taken[slot]     = 1'b1;
            key_of[slot]    = it.course_number;
            year_of[slot]   = it.course_year;
            prof_of[slot]   = it.prof_id;
            handle_of[slot] = it.record_handle;
            r.status        = qpht_pkg::STATUS_INSERTED;
            r.slot_index    = qpht_pkg::SLOT_W'(slot);
            break;
          end
        end else begin
          if (!taken[slot]) break;
          if (key_of[slot] == it.course_number && year_of[slot] == it.course_year &&
              prof_of[slot] == it.prof_id) begin
            r.status       = qpht_pkg::STATUS_FOUND;
            r.slot_index   = qpht_pkg::SLOT_W'(slot);
            r.found_handle = handle_of[slot];
            break;
          end
        end
      end
      if (32'(r.probe_count) > longest_walk) longest_walk = 32'(r.probe_count);
      awaited_outcomes = {awaited_outcomes, r};
    endfunction

    function void check_outcome(qpht_pkg::out_item_t got);
      qpht_pkg::out_item_t want;
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        $error("result item with nothing awaited: status %0d slot %0d", got.status,
               got.slot_index);
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      case (want.status)
        qpht_pkg::STATUS_INSERTED:  n_inserted++;
        qpht_pkg::STATUS_FOUND:     n_found++;
        qpht_pkg::STATUS_NOT_FOUND: n_missing++;
        default:                    n_full++;
      endcase
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.found_handle !== want.found_handle) begin
        $error("found_handle: expected %0h, got %0h", want.found_handle, got.found_handle);
        errors++;
      end
      if (got.probe_count !== want.probe_count) begin
        $error("probe_count: expected %0d, got %0d", want.probe_count, got.probe_count);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_outcomes.size();
    endfunction
  endclass

  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 128;
  localparam int HOLD_CYCLES = 300;

  // Table sizes of the random phases; a negative entry means a size picked at random.
  // Zero and values above the slot count are deliberately among them.
  int size_plan [PHASES] = '{3, 16, 1024, 0, 7, 200, 2047, 1, 61, 1500, -1, -1, 2, 1024, -1};

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  qpht_pkg::in_item_t          in_item   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  qpht_pkg::out_item_t         out_item;
  logic                        cfg_we    = 1'b0;
  logic [qpht_pkg::CFG_W-1:0]  cfg_wdata = '0;

  hash_outcome_scoreboard sb = new();

  // Key triples that have been offered for insertion, used to build lookups that hit.
  qpht_pkg::in_item_t inserted_keys[$];
  bit                 eager_send = 1'b0;
  bit                 eager_sink = 1'b0;
  int unsigned        cycle_limit = 20000;
  int                 sizes_written = 0;
  int                 long_holds = 0;

  quadratic_probe_hash_table u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Mostly no idling, sometimes a few cycles and now and then a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Random items are mostly well-formed: fresh inserts, lookups of keys already offered,
  // near misses on the same course number, duplicate inserts, and a little pure noise.
  function automatic qpht_pkg::in_item_t random_request();
    qpht_pkg::in_item_t it;
    int                 pick;
    int unsigned        at;
    it.mode          = qpht_pkg::MODE_INSERT;
    it.course_number = qpht_pkg::KEY_W'($urandom);
    it.course_year   = qpht_pkg::YEAR_W'($urandom);
    it.prof_id       = qpht_pkg::PROF_W'($urandom);
    it.record_handle = qpht_pkg::HANDLE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (inserted_keys.size() == 0 || pick < 40) return it;
    at = $urandom_range(0, inserted_keys.size() - 1);
    if (pick < 46) begin
      // Same course number, other year and professor: lengthens a collision chain.
      it.course_number = inserted_keys[at].course_number;
    end else if (pick < 72) begin
      it = inserted_keys[at];
      it.mode = qpht_pkg::MODE_LOOKUP;
      it.record_handle = qpht_pkg::HANDLE_W'($urandom);
    end else if (pick < 84) begin
      it = inserted_keys[at];
      it.mode = qpht_pkg::MODE_LOOKUP;
      if ($urandom_range(0, 1) == 0) begin
        it.course_year ^= qpht_pkg::YEAR_W'(1) << $urandom_range(0, qpht_pkg::YEAR_W - 1);
      end else begin
        it.prof_id ^= qpht_pkg::PROF_W'(1) << $urandom_range(0, qpht_pkg::PROF_W - 1);
      end
    end else if (pick < 92) begin
      it = inserted_keys[at];
      it.mode = qpht_pkg::MODE_INSERT;
      it.record_handle = qpht_pkg::HANDLE_W'($urandom);
    end else begin
      it.mode = ($urandom_range(0, 1) == 0) ? qpht_pkg::MODE_INSERT : qpht_pkg::MODE_LOOKUP;
    end
    return it;
  endfunction

  // Offers one item and returns in the time step of its acceptance, with valid still high
  // so that a following item can be offered back to back.
  task automatic drive_item(input qpht_pkg::in_item_t it);
    int gap;
    gap = eager_send ? 0 : idle_len();
    // Room for the slowest walk at the current size plus the longest stalls on both sides.
    cycle_limit += 4 * (sb.size_n + 200);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    if (it.mode == qpht_pkg::MODE_INSERT) begin
      inserted_keys = {inserted_keys, it};
      if (inserted_keys.size() > 400) void'(inserted_keys.pop_front());
    end
  endtask

  task automatic request(input logic mode, input logic [qpht_pkg::KEY_W-1:0] number,
                         input logic [qpht_pkg::YEAR_W-1:0] year,
                         input logic [qpht_pkg::PROF_W-1:0] prof,
                         input logic [qpht_pkg::HANDLE_W-1:0] handle);
    qpht_pkg::in_item_t it;
    it.mode          = mode;
    it.course_number = number;
    it.course_year   = year;
    it.prof_id       = prof;
    it.record_handle = handle;
    drive_item(it);
  endtask

  // Withdraws the input and waits until every awaited result has come back, then a few
  // cycles more so that the probe engine has settled.
  task automatic await_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [qpht_pkg::CFG_W-1:0] value);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(value);
    sizes_written++;
  endtask

  // Receiver: checks each result at the edge where it is taken, stalls at random, and
  // twice holds off for a long stretch while the sender keeps offering items, so that
  // the internal queue fills and the input side is throttled.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int next_hold_at;
    stall_left   = 0;
    hold_left    = 0;
    next_hold_at = 250;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_outcome(out_item);
      if (sb.results_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 900;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!eager_sink && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog: the limit grows with every item offered, so it only fires if the block
  // stops making progress. The clearing pass after reset is covered by the start value.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < cycle_limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("quadratic_probe_hash_table regression: fail");
    $finish;
  end

  initial begin : stimulus
    int value;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 1024 slots.
    // A lookup in the empty table stops at the first probe.
    request(qpht_pkg::MODE_LOOKUP, 16'h0000, 12'h000, 32'h0000_0000, 16'hFFFF);
    request(qpht_pkg::MODE_INSERT, 16'h0000, 12'h000, 32'h0000_0000, 16'h0000);
    request(qpht_pkg::MODE_INSERT, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF);
    request(qpht_pkg::MODE_LOOKUP, 16'h0000, 12'h000, 32'h0000_0000, 16'h0000);
    request(qpht_pkg::MODE_LOOKUP, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'h0000);
    // Duplicate insert: not detected, the copy takes the next empty slot of the walk.
    request(qpht_pkg::MODE_INSERT, 16'h0000, 12'h000, 32'h0000_0000, 16'h1234);
    // Same course number with other key parts lands further along the chain.
    request(qpht_pkg::MODE_INSERT, 16'h0000, 12'hABC, 32'h8000_0001, 16'h8001);
    request(qpht_pkg::MODE_LOOKUP, 16'h0000, 12'hABC, 32'h8000_0001, 16'h0000);
    // Professor differs in one bit: the walk passes the chain and ends at an empty slot.
    request(qpht_pkg::MODE_LOOKUP, 16'h0000, 12'hABC, 32'h8000_0000, 16'h0000);
    // Another course number with the same home slot misses as well.
    request(qpht_pkg::MODE_LOOKUP, 16'h0400, 12'h000, 32'h0000_0000, 16'h0000);

    // A single slot, already taken: inserts report a full table after one probe, and a
    // lookup that does not match gives up after that same probe.
    write_table_size(qpht_pkg::CFG_W'(1));
    request(qpht_pkg::MODE_INSERT, 16'h5555, 12'h555, 32'h5555_5555, 16'h5555);
    request(qpht_pkg::MODE_LOOKUP, 16'h0000, 12'h000, 32'h0000_0000, 16'h0000);
    request(qpht_pkg::MODE_LOOKUP, 16'hAAAA, 12'hAAA, 32'hAAAA_AAAA, 16'h0000);
    // A size of zero behaves as a size of one.
    write_table_size(qpht_pkg::CFG_W'(0));
    request(qpht_pkg::MODE_INSERT, 16'h0001, 12'h001, 32'h0000_0001, 16'h0001);
    // Shrunk to two slots: the record in the top slot is stored but out of reach.
    write_table_size(qpht_pkg::CFG_W'(2));
    request(qpht_pkg::MODE_LOOKUP, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'h0000);
    request(qpht_pkg::MODE_INSERT, 16'h0007, 12'h007, 32'h0000_0007, 16'h0007);
    // A size beyond the slot count behaves as the full table and the record is back.
    write_table_size(qpht_pkg::CFG_W'(2047));
    request(qpht_pkg::MODE_LOOKUP, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 16'h0000);

    // Random phases, one table size each; some phases run without idling on one side.
    for (int p = 0; p < PHASES; p++) begin
      value = size_plan[p];
      if (value < 0) begin
        value = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 64) : $urandom_range(65, 2047);
      end
      write_table_size(qpht_pkg::CFG_W'(value));
      eager_send = ($urandom_range(0, 3) == 0);
      eager_sink = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) drive_item(random_request());
    end

    await_idle();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("covered %0d results, %0d sizes: %0d inserted, %0d found, %0d not found, %0d full",
             sb.results_seen, sizes_written, sb.n_inserted, sb.n_found, sb.n_missing, sb.n_full);
    $display("longest probe walk %0d slots, %0d long receiver hold-offs, %0d mismatches",
             sb.longest_walk, long_holds, sb.errors);
    if (sb.errors == 0) begin
      $display("quadratic_probe_hash_table regression: pass");
    end else begin
      $display("quadratic_probe_hash_table regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/qpht_pkg.sv
design/qpht_front.sv
design/qpht_queue.sv
design/qpht_back.sv
design/quadratic_probe_hash_table.sv
design/qpht_checker.sv
tb/sv/tb_quadratic_probe_hash_table.sv
